// File: hw/rtl/shlpp_pkg.sv
// ----------------------------------------------------------------------------
// shlpp_pkg
// Shared types and constants of the sync-header length packet parser.
// ----------------------------------------------------------------------------
package shlpp_pkg;

  // default header layout, in bytes
  localparam int SyncBytesDef  = 2;
  localparam int IdBytesDef    = 4;
  localparam int SeqBytesDef   = 2;
  localparam int LenBytesDef   = 2;
  localparam int CrcBytesDef   = 2;
  localparam int QueueDepthDef = 2;

  // fixed field widths
  localparam int ByteW    = 8;
  localparam int PatternW = 16;
  localparam int IdW      = 32;
  localparam int SeqW     = 16;
  localparam int LenW     = 16;
  localparam int CrcW     = 16;
  localparam int CountW   = 16;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ID   = 3'd1,
    PH_TYPE = 3'd2,
    PH_SEQ  = 3'd3,
    PH_LEN  = 3'd4,
    PH_CRC  = 3'd5,
    PH_DATA = 3'd6
  } phase_t;

  // one result item as it moves through the queue
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             has_byte;
    logic             last;
    logic [ByteW-1:0] pkt_type;
    logic [IdW-1:0]   source_id;
    logic [SeqW-1:0]  sequence_number;
    logic [LenW-1:0]  payload_length;
    logic [CrcW-1:0]  header_crc;
  } res_t;

endpackage

// File: hw/rtl/shlpp_front.sv
// ----------------------------------------------------------------------------
// shlpp_front
// Byte parser: hunts for the sync word, gathers the header fields and emits
// one result per payload byte (or one empty result for a zero-length packet).
// ----------------------------------------------------------------------------
module shlpp_front #(
  parameter int SYNC_BYTES = shlpp_pkg::SyncBytesDef,
  parameter int ID_BYTES   = shlpp_pkg::IdBytesDef,
  parameter int SEQ_BYTES  = shlpp_pkg::SeqBytesDef,
  parameter int LEN_BYTES  = shlpp_pkg::LenBytesDef,
  parameter int CRC_BYTES  = shlpp_pkg::CrcBytesDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [shlpp_pkg::PatternW-1:0] cfg_data,
  input  logic                          byte_valid,
  input  logic [shlpp_pkg::ByteW-1:0]   byte_data,
  input  logic                          queue_full,
  output logic                          byte_ready,
  output logic                          push,
  output shlpp_pkg::res_t               push_data
);
  import shlpp_pkg::*;

  localparam logic [CountW-1:0] SyncLast = CountW'(SYNC_BYTES - 1);
  localparam logic [CountW-1:0] IdLast   = CountW'(ID_BYTES - 1);
  localparam logic [CountW-1:0] SeqLast  = CountW'(SEQ_BYTES - 1);
  localparam logic [CountW-1:0] LenLast  = CountW'(LEN_BYTES - 1);
  localparam logic [CountW-1:0] CrcLast  = CountW'(CRC_BYTES - 1);

  logic [PatternW-1:0] pattern_r;
  phase_t              phase_r, phase_nxt;
  logic [CountW-1:0]   count_r, count_nxt;
  logic [IdW-1:0]      id_r, id_nxt;
  logic [ByteW-1:0]    type_r, type_nxt;
  logic [SeqW-1:0]     seq_r, seq_nxt;
  logic [LenW-1:0]     len_r, len_nxt;
  logic [CrcW-1:0]     crc_r, crc_nxt;
  logic                take;
  logic [ByteW-1:0]    want;
  logic [CountW-1:0]   count_inc;
  logic                fin;

  assign byte_ready = !queue_full;
  assign take       = byte_valid && !queue_full;
  assign count_inc  = count_r + CountW'(1);
  assign fin        = (count_inc >= len_r);

  // expected sync byte, zero beyond the pattern register
  always_comb begin
    if (count_r == '0) begin
      want = pattern_r[ByteW-1:0];
    end else if (count_r == CountW'(1)) begin
      want = pattern_r[2*ByteW-1:ByteW];
    end else begin
      want = '0;
    end
  end

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    id_nxt    = id_r;
    type_nxt  = type_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    push      = 1'b0;
    push_data = '{payload_byte: byte_data, has_byte: 1'b1, last: fin,
                  pkt_type: type_r, source_id: id_r,
                  sequence_number: seq_r, payload_length: len_r,
                  header_crc: crc_r};
    if (take) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_data == want) begin
            if (count_r == SyncLast) begin
              phase_nxt = PH_ID;
              count_nxt = '0;
            end else begin
              count_nxt = count_inc;
            end
          end else begin
            count_nxt = '0;
          end
        end
        PH_ID: begin
          for (int i = 0; i < IdW / ByteW; i++) begin
            if (count_r == CountW'(i)) id_nxt[ByteW*i +: ByteW] = byte_data;
          end
          count_nxt = count_inc;
          if (count_r == IdLast) begin
            phase_nxt = PH_TYPE;
            count_nxt = '0;
          end
        end
        PH_TYPE: begin
          type_nxt  = byte_data;
          phase_nxt = PH_SEQ;
          count_nxt = '0;
        end
        PH_SEQ: begin
          for (int i = 0; i < SeqW / ByteW; i++) begin
            if (count_r == CountW'(i)) seq_nxt[ByteW*i +: ByteW] = byte_data;
          end
          count_nxt = count_inc;
          if (count_r == SeqLast) begin
            phase_nxt = PH_LEN;
            count_nxt = '0;
          end
        end
        PH_LEN: begin
          for (int i = 0; i < LenW / ByteW; i++) begin
            if (count_r == CountW'(i)) len_nxt[ByteW*i +: ByteW] = byte_data;
          end
          count_nxt = count_inc;
          if (count_r == LenLast) begin
            phase_nxt = PH_CRC;
            count_nxt = '0;
          end
        end
        PH_CRC: begin
          for (int i = 0; i < CrcW / ByteW; i++) begin
            if (count_r == CountW'(i)) crc_nxt[ByteW*i +: ByteW] = byte_data;
          end
          count_nxt = count_inc;
          if (count_r == CrcLast) begin
            count_nxt = '0;
            if (len_r == '0) begin
              // empty packet: one byteless result, then hunt again
              push      = 1'b1;
              push_data = '{payload_byte: '0, has_byte: 1'b0, last: 1'b1,
                            pkt_type: type_r, source_id: id_r,
                            sequence_number: seq_r, payload_length: len_r,
                            header_crc: crc_nxt};
              phase_nxt = PH_HUNT;
              id_nxt    = '0;
              type_nxt  = '0;
              seq_nxt   = '0;
              len_nxt   = '0;
              crc_nxt   = '0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          push      = 1'b1;
          count_nxt = count_inc;
          if (fin) begin
            phase_nxt = PH_HUNT;
            count_nxt = '0;
            id_nxt    = '0;
            type_nxt  = '0;
            seq_nxt   = '0;
            len_nxt   = '0;
            crc_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          id_nxt    = '0;
          type_nxt  = '0;
          seq_nxt   = '0;
          len_nxt   = '0;
          crc_nxt   = '0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      id_r      <= '0;
      type_r    <= '0;
      seq_r     <= '0;
      len_r     <= '0;
      crc_r     <= '0;
    end else begin
      if (cfg_valid) pattern_r <= cfg_data;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      id_r    <= id_nxt;
      type_r  <= type_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

// File: hw/rtl/shlpp_queue.sv
// ----------------------------------------------------------------------------
// shlpp_queue
// Short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module shlpp_queue #(
  parameter int DEPTH = shlpp_pkg::QueueDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  shlpp_pkg::res_t push_data,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output shlpp_pkg::res_t pop_data
);
  import shlpp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  res_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CntW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: hw/rtl/sync_header_length_packet_parser_core.sv
// ----------------------------------------------------------------------------
// sync_header_length_packet_parser_core
// Sync-word hunter and length-prefixed packet deframer with header fields.
// ----------------------------------------------------------------------------
// A result is written into the result queue when the byte that causes it is
// taken. Throughput: one byte per cycle; the parser stalls only when the result
// queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, synchronous): sync word cleared to zero, parser back to
// hunting, header fields cleared, result queue emptied.
module sync_header_length_packet_parser_core #(
  parameter int SYNC_BYTES  = shlpp_pkg::SyncBytesDef,
  parameter int ID_BYTES    = shlpp_pkg::IdBytesDef,
  parameter int SEQ_BYTES   = shlpp_pkg::SeqBytesDef,
  parameter int LEN_BYTES   = shlpp_pkg::LenBytesDef,
  parameter int CRC_BYTES   = shlpp_pkg::CrcBytesDef,
  parameter int QUEUE_DEPTH = shlpp_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: start_pattern
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // payload_byte, source_id, sequence_number,
                                  // payload_length, header_crc
  output logic [8:0]  out_tuser,  // has_byte, pkt_type
  output logic        out_tlast
);
  import shlpp_pkg::*;

  logic full;
  logic push;
  res_t push_data;
  res_t pop_data;

  assign cfg_ready = 1'b1;

  // parser
  shlpp_front #(
    .SYNC_BYTES (SYNC_BYTES),
    .ID_BYTES   (ID_BYTES),
    .SEQ_BYTES  (SEQ_BYTES),
    .LEN_BYTES  (LEN_BYTES),
    .CRC_BYTES  (CRC_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .byte_valid (in_tvalid),
    .byte_data  (in_tdata),
    .queue_full (full),
    .byte_ready (in_tready),
    .push       (push),
    .push_data  (push_data)
  );

  // result queue
  shlpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (pop_data)
  );

  // output packing
  assign out_tdata = {pop_data.header_crc, pop_data.payload_length,
                      pop_data.sequence_number, pop_data.source_id,
                      pop_data.payload_byte};
  assign out_tuser = {pop_data.pkt_type, pop_data.has_byte};
  assign out_tlast = pop_data.last;

  // the parser never offers a result into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("result pushed into full queue");

  // an empty-packet result is always the last of its packet
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata[7:0] == 8'd0))
    else $error("byteless result not marked last or carries data");

  // after a result is pushed, the output holds a valid result the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid) else $error("pushed result not visible");

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("results present after reset");

endmodule
